FILE: src/a2ab_pkg.sv
// a2ab_pkg: shared constants and types for the avcc to annex b converter
// no dependencies; used by a2ab_obuf and avcc_to_annexb_converter
package a2ab_pkg;

	// parameter set store depth in bytes (16 to 56)
	localparam int PSET_BYTES   = 56;
	// sample nal length prefix, fixed at four bytes
	localparam int LENGTH_BYTES = 4;
	// store prefix / long start code length
	localparam int START_LONG   = 4;

	localparam int PS_IDX_W  = $clog2(PSET_BYTES);
	localparam int PS_FILL_W = $clog2(PSET_BYTES + 1);

	localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;
	localparam logic [7:0] NAL_TYPE_IDR  = 8'd5;

	typedef enum logic [1:0] {
		ST_DATA       = 2'd0,
		ST_BAD_LEN    = 2'd1,
		ST_BAD_EXTRA  = 2'd2,
		ST_STORE_FULL = 2'd3
	} status_t;

	// one result word as it travels to the output register
	typedef struct packed {
		logic [7:0] data;
		status_t    status;
		logic       last;
	} result_t;

endpackage

FILE: src/avcc_to_annexb_converter.sv
// avcc_to_annexb_converter: length-prefixed h.264 to start-code stream rewriter
// depends on a2ab_pkg and a2ab_obuf
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------
//   input   | in_valid / in_ready | mode, in_byte, in_last
//   output  | out_valid/out_ready | out_byte, status, run_last
//
// one input word is taken at a time; the next word is taken only once every
// result of the last one has been handed to the output register
// an idr first byte streams the stored parameter sets, read through a registered
// store read stage, before its start code; a sps/pps size byte that passes the
// fit check writes the four prefix bytes through the single store write port
// output stalls hold the sequencer; results leave through one output register
// reset clears all control state at once; the store needs no clearing pass
module avcc_to_annexb_converter import a2ab_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       mode,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] status,
	output logic       run_last
);

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,   // waiting for an input word
		S_WPFX,   // writing the 00 00 00 01 prefix into the store
		S_PSET,   // streaming stored parameter sets out
		S_START,  // emitting a start code
		S_TAIL    // emitting the payload byte or an error word
	} state_t;

	// extradata parse phases
	typedef enum logic [2:0] {
		PH_SKIP,
		PH_LSIZE,
		PH_SCOUNT,
		PH_SIZE_HI,
		PH_SIZE_LO,
		PH_BODY,
		PH_PCOUNT,
		PH_DONE
	} phase_t;

	localparam logic [PS_FILL_W-1:0] FILL_MAX = PS_FILL_W'(PSET_BYTES);
	localparam logic [1:0] HDR_SKIP_LAST = 2'd3;  // four header bytes skipped
	localparam logic [1:0] LBI_LAST      = 2'(LENGTH_BYTES - 1);
	localparam logic [1:0] SC_ONE_IDX    = 2'(START_LONG - 1);  // 01 byte slot
	localparam logic [1:0] SC_SHORT_IDX  = 2'd1;  // short code skips one zero

	state_t               state_q;
	phase_t               phase_q;
	logic [1:0]           xidx_q;      // header skip count, or 0 sps / 1 pps
	logic [7:0]           units_q;
	logic [15:0]          ubl_q;       // unit bytes left
	logic [PS_FILL_W-1:0] fill_q;
	logic [31:0]          acc_q;       // nal length being gathered
	logic [1:0]           lbi_q;       // length byte index
	logic [31:0]          nbl_q;       // nal bytes left
	logic                 first_q;     // next start code is the long form
	logic                 drop_q;      // skip the rest of a failed packet

	// plan for the words caused by the current input
	logic                 sc_en_q;
	logic                 tail_en_q;
	logic [7:0]           tail_byte_q;
	status_t              tail_st_q;
	logic [1:0]           cnt_q;       // prefix write / start code byte counter

	// store read pipeline
	logic [PS_FILL_W-1:0] rd_idx_q;
	logic                 pv_s1;
	logic [7:0]           rd_data_s1;
	logic [7:0]           pstore [PSET_BYTES];

	// next-state values for an accepted word
	phase_t               n_phase;
	phase_t               phase_after_unit;
	logic [1:0]           n_xidx;
	logic [7:0]           n_units;
	logic [7:0]           units_dec;
	logic [15:0]          n_ubl;
	logic [15:0]          ubl_lo;
	logic [15:0]          ubl_dec;
	logic [PS_FILL_W-1:0] n_fill;
	logic [31:0]          n_acc;
	logic [31:0]          acc_sh;
	logic [1:0]           n_lbi;
	logic [31:0]          n_nbl;
	logic                 n_first;
	logic                 n_drop;
	logic [16:0]          ext_sum;
	logic                 x_err;
	logic                 s_fail;
	logic                 p_wpfx;
	logic                 p_ps;
	logic                 p_sc;
	logic                 p_tail;
	logic [7:0]           p_byte;
	status_t              p_st;
	logic                 body_we;

	logic                 accept;
	logic                 rd_en;
	logic                 mem_we;
	logic [7:0]           mem_wdata;
	logic                 push_valid;
	logic                 push_ready;
	result_t              push_word;
	result_t              out_word;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// per-word decode: parse step, packet step and the result plan
	always_comb begin
		n_phase = phase_q;
		n_xidx  = xidx_q;
		n_units = units_q;
		n_ubl   = ubl_q;
		n_fill  = fill_q;
		n_acc   = acc_q;
		n_lbi   = lbi_q;
		n_nbl   = nbl_q;
		n_first = first_q;
		n_drop  = drop_q;
		x_err   = 1'b0;
		s_fail  = 1'b0;
		p_wpfx  = 1'b0;
		p_ps    = 1'b0;
		p_sc    = 1'b0;
		p_tail  = 1'b0;
		p_byte  = in_byte;
		p_st    = ST_DATA;
		body_we = 1'b0;

		ubl_lo    = {ubl_q[15:8], in_byte};
		ubl_dec   = ubl_q - 16'd1;
		ext_sum   = 17'(fill_q) + 17'(START_LONG) + {1'b0, ubl_lo};
		units_dec = units_q - 8'd1;
		// where a finished unit leads: next unit, pps count, or done
		if (units_dec != 8'd0) begin
			phase_after_unit = PH_SIZE_HI;
		end else if (xidx_q == 2'd0) begin
			phase_after_unit = PH_PCOUNT;
		end else begin
			phase_after_unit = PH_DONE;
		end
		acc_sh = {acc_q[23:0], in_byte};

		if (!mode) begin
			unique case (phase_q)
				PH_SKIP: begin
					// first header byte of a new extradata empties the store
					if (xidx_q == 2'd0) n_fill = '0;
					if (xidx_q == HDR_SKIP_LAST) begin
						n_xidx  = 2'd0;
						n_phase = PH_LSIZE;
					end else begin
						n_xidx = xidx_q + 2'd1;
					end
				end
				PH_LSIZE: n_phase = PH_SCOUNT;
				PH_SCOUNT: begin
					n_units = in_byte & NAL_TYPE_MASK;
					n_xidx  = 2'd0;
					n_phase = ((in_byte & NAL_TYPE_MASK) != 8'd0) ? PH_SIZE_HI : PH_PCOUNT;
				end
				PH_SIZE_HI: begin
					n_ubl   = {in_byte, 8'h00};
					n_phase = PH_SIZE_LO;
				end
				PH_SIZE_LO: begin
					n_ubl = ubl_lo;
					if (ext_sum > 17'(PSET_BYTES)) begin
						// unit plus prefix would not fit
						x_err   = 1'b1;
						p_tail  = 1'b1;
						p_byte  = 8'h00;
						p_st    = ST_STORE_FULL;
						n_fill  = '0;
						n_phase = PH_DONE;
					end else begin
						p_wpfx = 1'b1;
						if (ubl_lo == 16'd0) begin
							n_units = units_dec;
							n_phase = phase_after_unit;
						end else begin
							n_phase = PH_BODY;
						end
					end
				end
				PH_BODY: begin
					if (fill_q < FILL_MAX) begin
						body_we = 1'b1;
						n_fill  = fill_q + PS_FILL_W'(1);
					end
					n_ubl = ubl_dec;
					if (ubl_dec == 16'd0) begin
						n_units = units_dec;
						n_phase = phase_after_unit;
					end
				end
				PH_PCOUNT: begin
					n_units = in_byte;
					n_xidx  = 2'd1;
					n_phase = (in_byte != 8'd0) ? PH_SIZE_HI : PH_DONE;
				end
				PH_DONE: begin
				end
			endcase
			if (in_last) begin
				// extradata cut short before the last pps unit
				if (n_phase != PH_DONE && !x_err) begin
					p_tail = 1'b1;
					p_byte = 8'h00;
					p_st   = ST_BAD_EXTRA;
					n_fill = '0;
					p_wpfx = 1'b0;
				end
				n_phase = PH_SKIP;
				n_xidx  = 2'd0;
			end
		end else begin
			if (drop_q) begin
				// rest of a failed packet: nothing out
			end else if (nbl_q == 32'd0) begin
				// gathering a big-endian length
				n_acc = acc_sh;
				if (lbi_q != LBI_LAST) begin
					n_lbi = lbi_q + 2'd1;
					if (in_last) s_fail = 1'b1;
				end else begin
					n_lbi = 2'd0;
					if (acc_sh[31]) begin
						s_fail = 1'b1;
					end else if (acc_sh == 32'd0) begin
						// zero-length nal: start code alone
						p_sc    = 1'b1;
						n_first = 1'b0;
					end else if (in_last) begin
						s_fail = 1'b1;
					end else begin
						n_nbl = acc_sh;
					end
				end
			end else begin
				if (in_last && nbl_q > 32'd1) begin
					s_fail = 1'b1;
				end else begin
					if (nbl_q == acc_q) begin
						// first byte of a nal: idr gets the parameter sets first
						if ((in_byte & NAL_TYPE_MASK) == NAL_TYPE_IDR) p_ps = 1'b1;
						p_sc    = 1'b1;
						n_first = 1'b0;
					end
					p_tail = 1'b1;
					p_byte = in_byte;
					p_st   = ST_DATA;
					n_nbl  = nbl_q - 32'd1;
				end
			end
			if (s_fail) begin
				p_tail = 1'b1;
				p_byte = 8'h00;
				p_st   = ST_BAD_LEN;
				n_lbi  = 2'd0;
				n_acc  = 32'd0;
				n_nbl  = 32'd0;
				n_drop = !in_last;
			end
			if (in_last) begin
				n_first = 1'b1;
				n_drop  = 1'b0;
				n_lbi   = 2'd0;
				n_acc   = 32'd0;
				n_nbl   = 32'd0;
			end
		end
	end

	// word handed to the output register in each emitting state
	always_comb begin
		push_valid = 1'b0;
		push_word  = '0;
		rd_en      = 1'b0;
		unique case (state_q)
			S_PSET: begin
				push_valid     = pv_s1;
				push_word.data = rd_data_s1;
				// fetch the next store byte while the slot can move on
				rd_en = (rd_idx_q != fill_q) && (!pv_s1 || push_ready);
			end
			S_START: begin
				push_valid     = 1'b1;
				push_word.data = (cnt_q == SC_ONE_IDX) ? 8'h01 : 8'h00;
				push_word.last = (cnt_q == SC_ONE_IDX) && !tail_en_q;
			end
			S_TAIL: begin
				push_valid       = 1'b1;
				push_word.data   = tail_byte_q;
				push_word.status = tail_st_q;
				push_word.last   = 1'b1;
			end
			S_IDLE, S_WPFX: begin
			end
			default: begin
			end
		endcase
	end

	// store write port: body bytes at accept, prefix bytes in their own state
	assign mem_we = (accept && !mode && body_we) ||
		(state_q == S_WPFX && fill_q < FILL_MAX);
	assign mem_wdata = (state_q == S_WPFX) ?
		((cnt_q == SC_ONE_IDX) ? 8'h01 : 8'h00) : in_byte;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pstore[fill_q[PS_IDX_W-1:0]] <= mem_wdata;
		end
		if (rd_en) begin
			rd_data_s1 <= pstore[rd_idx_q[PS_IDX_W-1:0]];
		end
	end

	// sequencer, parse state and result plan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_SKIP;
			xidx_q      <= 2'd0;
			units_q     <= 8'd0;
			ubl_q       <= 16'd0;
			fill_q      <= '0;
			acc_q       <= 32'd0;
			lbi_q       <= 2'd0;
			nbl_q       <= 32'd0;
			first_q     <= 1'b1;
			drop_q      <= 1'b0;
			sc_en_q     <= 1'b0;
			tail_en_q   <= 1'b0;
			tail_byte_q <= 8'h00;
			tail_st_q   <= ST_DATA;
			cnt_q       <= 2'd0;
			rd_idx_q    <= '0;
			pv_s1       <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						phase_q     <= n_phase;
						xidx_q      <= n_xidx;
						units_q     <= n_units;
						ubl_q       <= n_ubl;
						fill_q      <= n_fill;
						acc_q       <= n_acc;
						lbi_q       <= n_lbi;
						nbl_q       <= n_nbl;
						first_q     <= n_first;
						drop_q      <= n_drop;
						sc_en_q     <= p_sc;
						tail_en_q   <= p_tail;
						tail_byte_q <= p_byte;
						tail_st_q   <= p_st;
						// long start code begins at the first zero, short skips one
						cnt_q       <= (!mode || first_q) ? 2'd0 : SC_SHORT_IDX;
						rd_idx_q    <= '0;
						pv_s1       <= 1'b0;
						if (p_wpfx) begin
							state_q <= S_WPFX;
						end else if (p_ps && fill_q != '0) begin
							state_q <= S_PSET;
						end else if (p_sc) begin
							state_q <= S_START;
						end else if (p_tail) begin
							state_q <= S_TAIL;
						end
					end
				end
				S_WPFX: begin
					if (fill_q < FILL_MAX) fill_q <= fill_q + PS_FILL_W'(1);
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == SC_ONE_IDX) state_q <= S_IDLE;
				end
				S_PSET: begin
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + PS_FILL_W'(1);
						pv_s1    <= 1'b1;
					end else if (push_ready) begin
						pv_s1 <= 1'b0;
					end
					// last store byte handed over: start code follows
					if (pv_s1 && push_ready && rd_idx_q == fill_q) begin
						state_q <= sc_en_q ? S_START : S_IDLE;
					end
				end
				S_START: begin
					if (push_ready) begin
						cnt_q <= cnt_q + 2'd1;
						if (cnt_q == SC_ONE_IDX) state_q <= tail_en_q ? S_TAIL : S_IDLE;
					end
				end
				S_TAIL: begin
					if (push_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a2ab_obuf u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_word  (push_word),
		.push_ready (push_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_word   (out_word)
	);

	assign out_byte = out_word.data;
	assign status   = out_word.status;
	assign run_last = out_word.last;

`ifndef ASSERT_OFF
	// store never holds more than its depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_MAX)
		else $error("parameter store fill past depth");

	// reads and writes of the store never share a cycle
	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !mem_we)
		else $error("store read and write in the same cycle");

	// pending store data only lives while streaming the store
	a_pv_scope: assert property (@(posedge clk) disable iff (!arst_n)
		pv_s1 |-> (state_q == S_PSET && rd_idx_q <= fill_q))
		else $error("store read pipeline out of step");

	// a dropped packet keeps no length or payload count
	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> (nbl_q == 32'd0 && lbi_q == 2'd0))
		else $error("drop state with live nal counters");
`endif

endmodule

FILE: src/a2ab_obuf.sv
// a2ab_obuf: single-entry output register for result words
// depends on a2ab_pkg (result_t)
module a2ab_obuf import a2ab_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	input  result_t push_word,
	output logic    push_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_word
);

	logic    valid_q;
	result_t word_q;

	// slot frees up in the same cycle the downstream takes the word
	assign push_ready = !valid_q || out_ready;
	assign out_valid  = valid_q;
	assign out_word   = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push_ready) begin
			valid_q <= push_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid && push_ready) begin
			word_q <= push_word;
		end
	end

endmodule

FILE: test/avcc_to_annexb_converter_tb.sv
// avcc_to_annexb_converter_tb: self-checking bench for the avcc to annex b converter
// depends on a2ab_pkg and avcc_to_annexb_converter; each accepted word is run through
// an in-bench predictor and every result word is compared against the oldest prediction
module avcc_to_annexb_converter_tb;
	import a2ab_pkg::*;

	localparam logic MODE_EXTRA  = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;
	localparam int   CYCLE_LIMIT  = 1000000;
	localparam int   RANDOM_WORDS = 30;
	localparam int   TAIL_CYCLES  = 16;

	// decoder configuration record parse steps
	typedef enum logic [2:0] {
		XP_SKIP, XP_LSIZE, XP_SCOUNT, XP_SIZE_HI, XP_SIZE_LO, XP_BODY, XP_PCOUNT, XP_DONE
	} extra_phase_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       mode      = 1'b0;
	logic [7:0] in_byte   = 8'h00;
	logic       in_last   = 1'b0;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic       run_last;

	avcc_to_annexb_converter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.status    (status),
		.run_last  (run_last)
	);

	always #5 clk = ~clk;

	// predictor state, mirrors the converter after reset
	logic [7:0]   ps_mem [PSET_BYTES];
	int           ps_fill   = 0;
	extra_phase_t xph       = XP_SKIP;
	int           xidx      = 0;
	logic [7:0]   units_left = 8'h00;
	logic [15:0]  unit_left = 16'h0000;
	logic [31:0]  len_acc   = 32'h0;
	int           len_idx   = 0;
	logic [31:0]  nal_left  = 32'h0;
	bit           first_nal = 1'b1;
	bit           dropping  = 1'b0;

	result_t    burst[$];       // results of the word being predicted
	result_t    annexb_due[$];  // predicted result words not yet seen
	logic [7:0] octets[$];      // word run being built
	result_t    seen, want;
	int         mismatches = 0;
	int         words_sent = 0;
	int         idle_odds  = 4;  // one idle burst in this many chances, 0 = none
	int         cycles     = 0;
	int         stall_left = 0;

	// ---------------- predictor ----------------

	function automatic void emit(input logic [7:0] b, input status_t st);
		result_t r;
		r.data = b;
		r.status = st;
		r.last = 1'b0;
		burst.push_back(r);
	endfunction

	function automatic void emit_start();
		if (first_nal) emit(8'h00, ST_DATA);
		emit(8'h00, ST_DATA);
		emit(8'h00, ST_DATA);
		emit(8'h01, ST_DATA);
		first_nal = 1'b0;
	endfunction

	function automatic void store_put(input logic [7:0] b);
		if (ps_fill < PSET_BYTES) begin
			ps_mem[ps_fill] = b;
			ps_fill++;
		end
	endfunction

	function automatic void extra_abort(input status_t st);
		emit(8'h00, st);
		ps_fill = 0;
		xph = XP_DONE;
	endfunction

	function automatic void unit_finish();
		units_left = units_left - 8'd1;
		if (units_left == 0)
			xph = (xidx == 0) ? XP_PCOUNT : XP_DONE;
		else
			xph = XP_SIZE_HI;
	endfunction

	function automatic void parse_extra(input logic [7:0] b, input logic l);
		bit failed;
		failed = 1'b0;
		case (xph)
		XP_SKIP: begin
			// first header byte of a new record empties the store
			if (xidx == 0) ps_fill = 0;
			if (xidx >= 3) begin
				xidx = 0;
				xph = XP_LSIZE;
			end else begin
				xidx++;
			end
		end
		XP_LSIZE: xph = XP_SCOUNT;
		XP_SCOUNT: begin
			units_left = b & NAL_TYPE_MASK;
			xidx = 0;
			xph = (units_left != 0) ? XP_SIZE_HI : XP_PCOUNT;
		end
		XP_SIZE_HI: begin
			unit_left = {b, 8'h00};
			xph = XP_SIZE_LO;
		end
		XP_SIZE_LO: begin
			unit_left = {unit_left[15:8], b};
			if (ps_fill + 4 + int'(unit_left) > PSET_BYTES) begin
				extra_abort(ST_STORE_FULL);
				failed = 1'b1;
			end else begin
				store_put(8'h00);
				store_put(8'h00);
				store_put(8'h00);
				store_put(8'h01);
				if (unit_left == 0) unit_finish();
				else xph = XP_BODY;
			end
		end
		XP_BODY: begin
			store_put(b);
			unit_left = unit_left - 16'd1;
			if (unit_left == 0) unit_finish();
		end
		XP_PCOUNT: begin
			units_left = b;
			xidx = 1;
			xph = (units_left != 0) ? XP_SIZE_HI : XP_DONE;
		end
		default: ;
		endcase
		if (l) begin
			if (xph != XP_DONE && !failed) extra_abort(ST_BAD_EXTRA);
			xph = XP_SKIP;
			xidx = 0;
		end
	endfunction

	function automatic void packet_reset();
		first_nal = 1'b1;
		dropping = 1'b0;
		len_idx = 0;
		len_acc = 32'h0;
		nal_left = 32'h0;
	endfunction

	function automatic void sample_abort(input logic l);
		emit(8'h00, ST_BAD_LEN);
		len_idx = 0;
		len_acc = 32'h0;
		nal_left = 32'h0;
		dropping = !l;
	endfunction

	function automatic void parse_sample(input logic [7:0] b, input logic l);
		if (!dropping) begin
			if (nal_left == 0) begin
				len_acc = {len_acc[23:0], b};
				if (len_idx < LENGTH_BYTES - 1) begin
					len_idx++;
					if (l) sample_abort(l);
				end else begin
					len_idx = 0;
					if (len_acc[31]) sample_abort(l);
					else if (len_acc == 0) emit_start();
					else if (l) sample_abort(l);
					else nal_left = len_acc;
				end
			end else if (l && nal_left > 1) begin
				sample_abort(l);
			end else begin
				if (nal_left == len_acc) begin
					// idr nal: parameter sets go out ahead of its start code
					if ((b & NAL_TYPE_MASK) == NAL_TYPE_IDR)
						for (int i = 0; i < ps_fill; i++) emit(ps_mem[i], ST_DATA);
					emit_start();
				end
				emit(b, ST_DATA);
				nal_left = nal_left - 32'd1;
			end
		end
		if (l) packet_reset();
	endfunction

	function automatic void convert_word(input logic m, input logic [7:0] b, input logic l);
		burst.delete();
		if (m == MODE_EXTRA) parse_extra(b, l);
		else parse_sample(b, l);
		if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
		foreach (burst[i]) annexb_due.push_back(burst[i]);
	endfunction

	// ---------------- driving ----------------

	// called at a rising edge; returns at the edge that takes the word
	task automatic send_word(input logic m, input logic [7:0] b, input logic l);
		int gap;
		bit took;
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		in_byte <= b;
		in_last <= l;
		do begin
			@(negedge clk);
			took = in_ready;
			if (took) begin
				convert_word(m, b, l);
				words_sent++;
			end
			@(posedge clk);
		end while (!took);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (annexb_due.size() != 0);
	endtask

	// sends the built run with in_last on its final word, optionally cut short
	task automatic flush_run(input logic m, input bit cut);
		int n;
		n = octets.size();
		if (cut && n > 1) n = $urandom_range(1, n - 1);
		for (int i = 0; i < n; i++) send_word(m, octets[i], i == n - 1);
		octets.delete();
	endtask

	function automatic logic [7:0] rand_octet();
		return 8'($urandom);
	endfunction

	function automatic void add_len(input logic [31:0] v);
		octets.push_back(v[31:24]);
		octets.push_back(v[23:16]);
		octets.push_back(v[15:8]);
		octets.push_back(v[7:0]);
	endfunction

	function automatic void add_nal(input int n, input bit idr);
		logic [7:0] head;
		add_len(32'(n));
		if (n == 0) return;
		head = rand_octet();
		if (idr) head[4:0] = NAL_TYPE_IDR[4:0];
		else if ((head & NAL_TYPE_MASK) == NAL_TYPE_IDR) head[0] = ~head[0];
		octets.push_back(head);
		repeat (n - 1) octets.push_back(rand_octet());
	endfunction

	// record header: four skipped bytes, length-size byte, sps count byte
	function automatic void add_header(input logic [7:0] sps_count);
		octets.push_back(8'h01);
		octets.push_back(8'h64);
		octets.push_back(8'h00);
		octets.push_back(8'h1f);
		octets.push_back(8'hff);
		octets.push_back(sps_count);
	endfunction

	function automatic void add_unit(input int sz, input int body);
		octets.push_back(8'(sz >> 8));
		octets.push_back(8'(sz));
		repeat (body) octets.push_back(rand_octet());
	endfunction

	// one sps/pps unit, mostly small, sometimes filling or overflowing the store
	function automatic int random_unit(input int room);
		int sz, pick;
		pick = $urandom_range(0, 9);
		if (pick == 0 || room < 4) begin
			sz = room - 3 + $urandom_range(0, 300);
			if (sz < 0) sz = 0;
			add_unit(sz, $urandom_range(0, 2));
			return 0;
		end
		if (pick == 1) sz = room - 4;
		else sz = $urandom_range(0, (room - 4 < 6) ? room - 4 : 6);
		add_unit(sz, sz);
		return room - 4 - sz;
	endfunction

	task automatic random_extradata();
		int n_sps, n_pps, room;
		octets.delete();
		repeat (5) octets.push_back(rand_octet());
		n_sps = $urandom_range(0, 3);
		octets.push_back({3'($urandom_range(0, 7)), 5'(n_sps)});
		room = PSET_BYTES;
		repeat (n_sps) room = random_unit(room);
		n_pps = $urandom_range(0, 2);
		octets.push_back(8'(n_pps));
		repeat (n_pps) room = random_unit(room);
		if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) octets.push_back(rand_octet());
		flush_run(MODE_EXTRA, $urandom_range(0, 5) == 0);
	endtask

	task automatic random_packet();
		int n_nal, pick;
		octets.delete();
		n_nal = $urandom_range(1, 3);
		repeat (n_nal) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				add_len(32'h0);
			end else if (pick == 1) begin
				add_len({1'b1, 31'($urandom)});
				octets.push_back(rand_octet());
			end else begin
				add_nal($urandom_range(1, 5), $urandom_range(0, 2) == 0);
			end
		end
		flush_run(MODE_SAMPLE, $urandom_range(0, 5) == 0);
	endtask

	task automatic random_noise();
		octets.delete();
		repeat ($urandom_range(1, 8)) octets.push_back(rand_octet());
		flush_run(1'($urandom_range(0, 1)), 1'b0);
	endtask

	// ---------------- tests ----------------

	task automatic test_directed_stream();
		idle_odds = 4;
		add_header(8'he1);          // one sps, top three bits ignored
		add_unit(3, 3);
		octets.push_back(8'h01);    // one pps
		add_unit(1, 1);
		flush_run(MODE_EXTRA, 1'b0);
		// idr with store insertion, zero-length nal, plain nal
		add_nal(2, 1'b1);
		add_len(32'h0);
		add_nal(1, 1'b0);
		flush_run(MODE_SAMPLE, 1'b0);
		// hold the sender until the converter has emptied out
		wait_drained();
		add_nal(1, 1'b1);
		add_nal(3, 1'b0);
		flush_run(MODE_SAMPLE, 1'b0);
	endtask

	task automatic test_extradata_faults();
		// unit one byte too big for the store, tail ignored; idr then sees an empty store
		add_header(8'h01);
		add_unit(PSET_BYTES - 3, 2);
		flush_run(MODE_EXTRA, 1'b0);
		add_nal(1, 1'b1);
		flush_run(MODE_SAMPLE, 1'b0);
		// record ends while a second sps is still announced
		add_header(8'h02);
		add_unit(1, 1);
		flush_run(MODE_EXTRA, 1'b0);
		// idr arriving mid-record gets the store as it stands
		add_header(8'h01);
		add_unit(2, 2);
		foreach (octets[i]) send_word(MODE_EXTRA, octets[i], 1'b0);
		octets.delete();
		add_nal(2, 1'b1);
		flush_run(MODE_SAMPLE, 1'b0);
		// no pps, then bytes past the end of the record
		octets.push_back(8'h00);
		octets.push_back(rand_octet());
		octets.push_back(rand_octet());
		flush_run(MODE_EXTRA, 1'b0);
		add_nal(1, 1'b1);
		flush_run(MODE_SAMPLE, 1'b0);
		// no sps and no pps at all
		add_header(8'he0);
		octets.push_back(8'h00);
		flush_run(MODE_EXTRA, 1'b0);
		add_nal(1, 1'b1);
		flush_run(MODE_SAMPLE, 1'b0);
	endtask

	task automatic test_packet_faults();
		// huge length, rest of the packet dropped
		add_len(32'hffff_ffff);
		octets.push_back(rand_octet());
		octets.push_back(rand_octet());
		flush_run(MODE_SAMPLE, 1'b0);
		// smallest huge length on the final word
		add_len(32'h8000_0000);
		flush_run(MODE_SAMPLE, 1'b0);
		// largest legal length, packet ends on its first payload byte
		add_len(32'h7fff_ffff);
		octets.push_back(8'h65);
		flush_run(MODE_SAMPLE, 1'b0);
		// packet ends inside a length
		octets.push_back(8'h00);
		octets.push_back(8'h00);
		flush_run(MODE_SAMPLE, 1'b0);
		// packet ends right after a nonzero length
		add_len(32'd2);
		flush_run(MODE_SAMPLE, 1'b0);
		// zero-length nal closing the packet
		add_len(32'h0);
		flush_run(MODE_SAMPLE, 1'b0);
		// payload cut one byte short, final byte replaced by the error
		add_nal(3, 1'b1);
		void'(octets.pop_back());
		flush_run(MODE_SAMPLE, 1'b0);
		// error, then a whole nal that must be dropped
		add_len(32'h8000_0001);
		add_nal(1, 1'b0);
		flush_run(MODE_SAMPLE, 1'b0);
	endtask

	task automatic test_random_traffic();
		int start_count, pick;
		start_count = words_sent;
		while (words_sent - start_count < RANDOM_WORDS) begin
			pick = $urandom_range(0, 2);
			idle_odds = (pick == 0) ? 0 : (pick == 1) ? 3 : 8;
			pick = $urandom_range(0, 9);
			if (pick < 2) random_extradata();
			else if (pick < 8) random_packet();
			else random_noise();
			if ($urandom_range(0, 15) == 0) wait_drained();
		end
	endtask

	task automatic test_calm_tail();
		// no idling from here on; store filled exactly, then two idr nals
		idle_odds = 0;
		add_header(8'h01);
		add_unit(PSET_BYTES - 4, PSET_BYTES - 4);
		octets.push_back(8'h00);
		flush_run(MODE_EXTRA, 1'b0);
		add_nal(2, 1'b1);
		add_nal(1, 1'b1);
		flush_run(MODE_SAMPLE, 1'b0);
	endtask

	// ---------------- checking ----------------

	task automatic report_mismatch(input string what, input logic [7:0] got_v,
			input logic [7:0] want_v);
		if (mismatches < 50)
			$display("mismatch at cycle %0d: %s got %02h want %02h", cycles, what, got_v, want_v);
		mismatches++;
	endtask

	// result words are sampled mid-cycle and scored at the edge that takes them
	always begin
		@(negedge clk);
		if (arst_n && out_valid && out_ready) begin
			seen.data = out_byte;
			seen.status = status_t'(status);
			seen.last = run_last;
			@(posedge clk);
			if (annexb_due.size() == 0) begin
				report_mismatch("result with nothing pending", seen.data, 8'h00);
			end else begin
				want = annexb_due.pop_front();
				if (seen.data !== want.data)
					report_mismatch("out_byte", seen.data, want.data);
				if (seen.status !== want.status)
					report_mismatch("status", 8'(seen.status), 8'(want.status));
				if (seen.last !== want.last)
					report_mismatch("run_last", 8'(seen.last), 8'(want.last));
			end
		end
	end

	// receiver stalls in bursts of random length, none while idle_odds is 0
	always @(posedge clk) begin
		if (stall_left > 0) stall_left--;
		else if (idle_odds != 0 && $urandom_range(1, idle_odds + 2) == 1)
			stall_left = $urandom_range(1, 8);
		out_ready <= (stall_left == 0);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_stream();
		test_extradata_faults();
		test_packet_faults();
		test_random_traffic();
		test_calm_tail();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && annexb_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: avcc_to_annexb_converter.f
src/a2ab_pkg.sv
src/a2ab_obuf.sv
src/avcc_to_annexb_converter.sv
test/avcc_to_annexb_converter_tb.sv
